FILE: rtl/omc_pkg.sv
package omc_pkg;

    localparam int TABLE_DEPTH    = 1024;
    localparam int STABLE_FRAMES  = 8;
    localparam int BACKOFF_MAX    = 8;
    localparam int RECHECK_FRAMES = 16;
    localparam int SETTLE_FACTOR  = 4;
    localparam int STILL_CAP      = STABLE_FRAMES * BACKOFF_MAX * SETTLE_FACTOR;

    localparam int IDX_W   = $clog2(TABLE_DEPTH);
    localparam int STILL_W = $clog2(STILL_CAP + 1);
    localparam int BO_W    = $clog2(BACKOFF_MAX + 1) + 1;
    localparam int CMP_W   = STILL_W + BO_W + 4;
    localparam int EPOCH_W = 32;
    localparam int BOUND_W = 127;

    // input opcodes
    localparam logic OP_VISIT = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // configuration register indexes
    localparam logic CFG_SPLIT_EN  = 1'b0;
    localparam logic CFG_PASS_MODE = 1'b1;

    // pass filter modes
    localparam logic [1:0] PASS_ALL     = 2'd0;
    localparam logic [1:0] PASS_STATIC  = 2'd1;
    localparam logic [1:0] PASS_DYNAMIC = 2'd2;

    typedef struct packed {
        logic                 valid;
        logic                 moving;
        logic [STILL_W-1:0]   still;
        logic [BO_W-1:0]      backoff;
        logic [BOUND_W-1:0]   bounds;
        logic [EPOCH_W-1:0]   seen;
        logic [EPOCH_W-1:0]   checked;
    } t_entry;

    typedef struct packed {
        logic accept;
        logic clear_step;
        logic writeback;
    } t_cmd;

    typedef struct packed {
        logic need_lookup;
        logic clear_last;
    } t_status;

endpackage

FILE: rtl/omc_ctrl.sv
module omc_ctrl
    import omc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    busy
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOKUP
    } t_state;

    t_state r_state;
    logic   r_busy;

    always_comb begin
        o_cmd            = '0;
        o_cmd.accept     = (r_state == S_IDLE) && start;
        o_cmd.clear_step = (r_state == S_CLEAR);
        o_cmd.writeback  = (r_state == S_LOOKUP);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_busy  <= 1'b1;
        end else begin
            case (r_state)
                S_CLEAR: begin
                    if (i_status.clear_last) begin
                        r_state <= S_IDLE;
                        r_busy  <= 1'b0;
                    end
                end
                S_IDLE: begin
                    if (start && i_status.need_lookup) begin
                        r_state <= S_LOOKUP;
                        r_busy  <= 1'b1;
                    end
                end
                S_LOOKUP: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                end
                default: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                end
            endcase
        end
    end

    assign busy = r_busy;

endmodule

FILE: rtl/omc_datapath.sv
module omc_datapath
    import omc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_status            o_status,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [1:0]         i_cfg_data,
    input  logic               i_opcode,
    input  logic [9:0]         i_object_index,
    input  logic               i_is_skinned,
    input  logic signed [31:0] i_centre_x,
    input  logic signed [31:0] i_centre_y,
    input  logic signed [31:0] i_centre_z,
    input  logic [30:0]        i_bound_radius,
    output logic               o_valid,
    output logic               o_keep,
    output logic               o_moving
);

    t_entry r_mem [TABLE_DEPTH];

    logic               r_split_en;
    logic [1:0]         r_pass_mode;
    logic [EPOCH_W-1:0] r_epoch;
    logic [IDX_W-1:0]   r_clr_addr;
    logic [IDX_W-1:0]   r_idx;
    logic [BOUND_W-1:0] r_bounds;
    t_entry             r_rd_entry;
    logic               r_valid;
    logic               r_keep;
    logic               r_moving;

    t_entry             n_entry;
    logic               n_moving;
    logic [BOUND_W-1:0] in_bounds;
    logic               quick_moving;

    function automatic logic pass_filter(input logic [1:0] mode, input logic mov);
        logic k;
        case (mode)
            PASS_STATIC:  k = !mov;
            PASS_DYNAMIC: k = mov;
            default:      k = 1'b1;
        endcase
        return k;
    endfunction

    assign in_bounds = {i_centre_x, i_centre_y, i_centre_z, i_bound_radius};

    assign o_status.need_lookup = (i_opcode == OP_VISIT) && r_split_en && !i_is_skinned;
    assign o_status.clear_last  = &r_clr_addr;

    // skinned visits are always moving, split disabled gives static
    assign quick_moving = r_split_en;

    // classification of the looked-up entry
    always_comb begin
        t_entry             e;
        logic [EPOCH_W-1:0] since;
        logic [EPOCH_W-1:0] elapsed;
        logic               memo;
        logic               settled;
        logic               moved;
        logic [BO_W-1:0]    bo;
        logic [BO_W:0]      nb;
        logic [STILL_W-1:0] st;
        logic [STILL_W:0]   sum;
        logic [CMP_W-1:0]   promote_at;
        logic               mov;

        e       = r_rd_entry;
        since   = r_epoch - e.checked;
        memo    = e.valid && (e.seen == r_epoch);
        settled = e.valid && !e.moving
                  && (CMP_W'(e.still) >=
                      CMP_W'(STABLE_FRAMES * SETTLE_FACTOR) * CMP_W'(e.backoff))
                  && (since < EPOCH_W'(RECHECK_FRAMES));
        moved   = !e.valid || (e.bounds != r_bounds);
        elapsed = (!e.valid || since == '0) ? EPOCH_W'(1) : since;
        bo      = e.valid ? e.backoff : BO_W'(1);
        st      = e.valid ? e.still : '0;
        nb      = {bo, 1'b0};
        sum     = '0;

        if (moved) begin
            if (e.valid && !e.moving) begin
                bo = (nb > (BO_W+1)'(BACKOFF_MAX)) ? BO_W'(BACKOFF_MAX) : nb[BO_W-1:0];
            end
            st = '0;
        end else if (|elapsed[EPOCH_W-1:STILL_W]) begin
            st = STILL_W'(STILL_CAP);
        end else begin
            sum = {1'b0, st} + {1'b0, elapsed[STILL_W-1:0]};
            st  = (sum > (STILL_W+1)'(STILL_CAP)) ? STILL_W'(STILL_CAP) : sum[STILL_W-1:0];
        end

        promote_at = CMP_W'(STABLE_FRAMES) * CMP_W'(bo);
        mov        = CMP_W'(st) < promote_at;
        if (!mov && (CMP_W'(st) >= promote_at * CMP_W'(SETTLE_FACTOR))) begin
            bo = BO_W'(1);
        end

        if (memo) begin
            n_entry  = e;
            n_moving = e.moving;
        end else if (settled) begin
            n_entry      = e;
            n_entry.seen = r_epoch;
            n_moving     = 1'b0;
        end else begin
            n_entry.valid   = 1'b1;
            n_entry.moving  = mov;
            n_entry.still   = st;
            n_entry.backoff = bo;
            n_entry.bounds  = r_bounds;
            n_entry.seen    = r_epoch;
            n_entry.checked = r_epoch;
            n_moving        = mov;
        end
    end

    // table memory: clearing pass after reset, then read-modify-write per table visit
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_step) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_cmd.writeback) begin
            r_mem[r_idx] <= n_entry;
        end
        if (i_cmd.accept) begin
            r_rd_entry <= r_mem[i_object_index[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_idx    <= i_object_index[IDX_W-1:0];
            r_bounds <= in_bounds;
        end
        if (i_cmd.writeback) begin
            r_moving <= n_moving;
            r_keep   <= pass_filter(r_pass_mode, n_moving);
        end else begin
            r_moving <= quick_moving;
            r_keep   <= r_split_en ? pass_filter(r_pass_mode, quick_moving) : 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_split_en  <= 1'b1;
            r_pass_mode <= PASS_ALL;
            r_epoch     <= '0;
            r_clr_addr  <= '0;
            r_valid     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SPLIT_EN:  r_split_en  <= i_cfg_data[0];
                    CFG_PASS_MODE: r_pass_mode <= i_cfg_data;
                    default:       r_split_en  <= r_split_en;
                endcase
            end
            if (i_cmd.accept && i_opcode == OP_TICK) begin
                r_epoch <= r_epoch + EPOCH_W'(1);
            end
            if (i_cmd.clear_step) begin
                r_clr_addr <= r_clr_addr + IDX_W'(1);
            end
            r_valid <= i_cmd.writeback
                       || (i_cmd.accept && i_opcode == OP_VISIT && !o_status.need_lookup);
        end
    end

    assign o_valid  = r_valid;
    assign o_keep   = r_keep;
    assign o_moving = r_moving;

endmodule

FILE: rtl/object_mobility_classifier_core.sv
// object mobility classifier
// a request is taken on a clock edge with start high and busy low. opcode 0 is
// an object visit, opcode 1 a frame tick that advances the epoch and gives no
// result. each visit gives one result (keep, moving) on o_keep/o_moving,
// marked by o_valid for exactly one cycle; the receiver cannot stall.
// a table visit (split on, not skinned) reads the per-object entry on the edge
// that takes the request and writes it back on the next edge, where the result
// is registered; busy is high for one cycle, as the table memory is read then
// written. frame ticks, skinned visits and visits with split off leave busy
// low, and such a visit's result is registered on the edge that takes it.
// after reset the table is swept clear one entry a cycle, all 1024 entries,
// with busy high; configuration writes (i_cfg_we, i_cfg_idx, i_cfg_data) are
// taken at any edge and apply from the next request, but a pass mode written
// while a table visit is in flight already sets that visit's keep
module object_mobility_classifier_core
    import omc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [1:0]         i_cfg_data,
    input  logic               i_opcode,
    input  logic [9:0]         i_object_index,
    input  logic               i_is_skinned,
    input  logic signed [31:0] i_centre_x,
    input  logic signed [31:0] i_centre_y,
    input  logic signed [31:0] i_centre_z,
    input  logic [30:0]        i_bound_radius,
    output logic               o_valid,
    output logic               o_keep,
    output logic               o_moving
);

    t_cmd    cmd;
    t_status status;

    omc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_status (status),
        .o_cmd    (cmd),
        .busy     (busy)
    );

    omc_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_opcode       (i_opcode),
        .i_object_index (i_object_index),
        .i_is_skinned   (i_is_skinned),
        .i_centre_x     (i_centre_x),
        .i_centre_y     (i_centre_y),
        .i_centre_z     (i_centre_z),
        .i_bound_radius (i_bound_radius),
        .o_valid        (o_valid),
        .o_keep         (o_keep),
        .o_moving       (o_moving)
    );

endmodule

FILE: verif/omc_mobility_checker.sv
module omc_mobility_checker
    import omc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [1:0]         i_cfg_data,
    input  logic               i_opcode,
    input  logic [9:0]         i_object_index,
    input  logic               i_is_skinned,
    input  logic signed [31:0] i_centre_x,
    input  logic signed [31:0] i_centre_y,
    input  logic signed [31:0] i_centre_z,
    input  logic [30:0]        i_bound_radius,
    input  logic               o_valid,
    input  logic               o_keep,
    input  logic               o_moving,
    output int                 fail_count,
    output int                 pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        bit          keep;
        bit          moving;
        int unsigned seq;
    } t_verdict;

    t_verdict expected_verdicts[$];
    int unsigned visit_seq;

    // register copies
    bit       split_on;
    bit [1:0] filter_mode;

    // per-object history
    bit [EPOCH_W-1:0] epoch;
    bit               obj_valid   [TABLE_DEPTH];
    bit               obj_moving  [TABLE_DEPTH];
    int unsigned      obj_still   [TABLE_DEPTH];
    int unsigned      obj_backoff [TABLE_DEPTH];
    bit [BOUND_W-1:0] obj_bounds  [TABLE_DEPTH];
    bit [EPOCH_W-1:0] obj_seen    [TABLE_DEPTH];
    bit [EPOCH_W-1:0] obj_checked [TABLE_DEPTH];

    initial begin
        fail_count = 0;
        pending    = 0;
        visit_seq  = 0;
    end

    task automatic report_mismatch(input string what);
        $display("%0t ns mismatch: %s", $realtime, what);
        fail_count++;
    endtask

    function automatic bit classify_visit(input int unsigned idx, input bit [BOUND_W-1:0] bnd);
        bit               was_valid;
        bit [EPOCH_W-1:0] since;
        bit               changed;
        bit [63:0]        elapsed;
        bit [63:0]        total;
        int unsigned      promote_at;
        was_valid = obj_valid[idx];
        // same-frame memo
        if (was_valid && obj_seen[idx] == epoch)
            return obj_moving[idx];
        since = epoch - obj_checked[idx];
        // settled objects only look at their bounds every few frames
        if (was_valid && !obj_moving[idx] &&
            obj_still[idx] >= STABLE_FRAMES * obj_backoff[idx] * SETTLE_FACTOR &&
            since < RECHECK_FRAMES) begin
            obj_seen[idx] = epoch;
            return 1'b0;
        end
        changed = !was_valid || obj_bounds[idx] != bnd;
        elapsed = (!was_valid || since == 0) ? 64'd1 : 64'(since);
        if (!was_valid) begin
            obj_backoff[idx] = 1;
            obj_still[idx]   = 0;
        end
        if (changed) begin
            if (was_valid && !obj_moving[idx])
                obj_backoff[idx] = (obj_backoff[idx] * 2 > BACKOFF_MAX) ?
                                   BACKOFF_MAX : obj_backoff[idx] * 2;
            obj_still[idx] = 0;
        end else begin
            total = 64'(obj_still[idx]) + elapsed;
            obj_still[idx] = (total > 64'(STILL_CAP)) ? STILL_CAP : total[31:0];
        end
        obj_bounds[idx]  = bnd;
        obj_seen[idx]    = epoch;
        obj_checked[idx] = epoch;
        obj_valid[idx]   = 1'b1;
        promote_at = STABLE_FRAMES * obj_backoff[idx];
        obj_moving[idx] = obj_still[idx] < promote_at;
        // long rest: backoff back to its start
        if (!obj_moving[idx] && obj_still[idx] >= promote_at * SETTLE_FACTOR)
            obj_backoff[idx] = 1;
        return obj_moving[idx];
    endfunction

    always @(posedge i_clk) begin
        t_verdict want;
        t_verdict item;
        bit       kp;
        bit       mv;
        if (!i_rst_n) begin
            split_on    = 1'b1;
            filter_mode = PASS_ALL;
            epoch       = '0;
            expected_verdicts.delete();
            foreach (obj_valid[i])
                obj_valid[i] = 1'b0;
        end else begin
            if (o_valid !== 1'b0) begin
                if (expected_verdicts.size() == 0) begin
                    report_mismatch($sformatf("result with nothing outstanding keep=%b moving=%b",
                                              o_keep, o_moving));
                end else begin
                    want = expected_verdicts.pop_front();
                    if (o_keep !== want.keep)
                        report_mismatch($sformatf("visit %0d keep got %b want %b",
                                                  want.seq, o_keep, want.keep));
                    if (o_moving !== want.moving)
                        report_mismatch($sformatf("visit %0d moving got %b want %b",
                                                  want.seq, o_moving, want.moving));
                end
            end
            if (start === 1'b1 && busy === 1'b0) begin
                if (i_opcode == OP_TICK) begin
                    epoch = epoch + 1'b1;
                end else begin
                    if (!split_on) begin
                        kp = 1'b1;
                        mv = 1'b0;
                    end else begin
                        if (i_is_skinned)
                            mv = 1'b1;
                        else
                            mv = classify_visit(int'(i_object_index) % TABLE_DEPTH,
                                                {i_bound_radius, i_centre_z,
                                                 i_centre_y, i_centre_x});
                        case (filter_mode)
                            PASS_STATIC:  kp = !mv;
                            PASS_DYNAMIC: kp = mv;
                            default:      kp = 1'b1;
                        endcase
                    end
                    item.keep   = kp;
                    item.moving = mv;
                    item.seq    = visit_seq;
                    expected_verdicts.insert(expected_verdicts.size(), item);
                    visit_seq++;
                end
            end
            if (i_cfg_we === 1'b1) begin
                if (i_cfg_idx == CFG_SPLIT_EN)
                    split_on = i_cfg_data[0];
                else if (i_cfg_idx == CFG_PASS_MODE)
                    filter_mode = i_cfg_data;
            end
        end
        pending = expected_verdicts.size();
    end

endmodule

FILE: verif/tb_object_mobility_classifier_core.sv
module tb_object_mobility_classifier_core;
    timeunit 1ns;
    timeprecision 1ps;

    import omc_pkg::*;

    localparam logic [1:0] PASS_UNUSED = 2'd3;
    localparam int         CREW        = 12;
    localparam logic [31:0] EXT_MIN    = 32'h8000_0000;
    localparam logic [31:0] EXT_MAX    = 32'h7fff_ffff;

    logic               i_clk          = 1'b0;
    logic               i_rst_n        = 1'b0;
    logic               start          = 1'b0;
    logic               busy;
    logic               i_cfg_we       = 1'b0;
    logic               i_cfg_idx      = CFG_SPLIT_EN;
    logic [1:0]         i_cfg_data     = 2'd0;
    logic               i_opcode       = OP_VISIT;
    logic [9:0]         i_object_index = '0;
    logic               i_is_skinned   = 1'b0;
    logic signed [31:0] i_centre_x     = '0;
    logic signed [31:0] i_centre_y     = '0;
    logic signed [31:0] i_centre_z     = '0;
    logic [30:0]        i_bound_radius = '0;
    logic               o_valid;
    logic               o_keep;
    logic               o_moving;

    int fail_count;
    int pending_verdicts;

    // sender burst state
    int burst_left = 0;

    // objects revisited with mostly unchanged bounds, so that history builds up
    logic [9:0]         crew_index  [CREW];
    logic [BOUND_W-1:0] crew_bounds [CREW];

    always #6 i_clk = ~i_clk;

    object_mobility_classifier_core DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_opcode       (i_opcode),
        .i_object_index (i_object_index),
        .i_is_skinned   (i_is_skinned),
        .i_centre_x     (i_centre_x),
        .i_centre_y     (i_centre_y),
        .i_centre_z     (i_centre_z),
        .i_bound_radius (i_bound_radius),
        .o_valid        (o_valid),
        .o_keep         (o_keep),
        .o_moving       (o_moving)
    );

    omc_mobility_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_opcode       (i_opcode),
        .i_object_index (i_object_index),
        .i_is_skinned   (i_is_skinned),
        .i_centre_x     (i_centre_x),
        .i_centre_y     (i_centre_y),
        .i_centre_z     (i_centre_z),
        .i_bound_radius (i_bound_radius),
        .o_valid        (o_valid),
        .o_keep         (o_keep),
        .o_moving       (o_moving),
        .fail_count     (fail_count),
        .pending        (pending_verdicts)
    );

    function automatic logic [BOUND_W-1:0] rand_bounds();
        return {31'($urandom()), $urandom(), $urandom(), $urandom()};
    endfunction

    function automatic logic [BOUND_W-1:0] pack_bounds(input logic [31:0] x, input logic [31:0] y,
                                                      input logic [31:0] z,
                                                      input logic [30:0] r);
        return {r, z, y, x};
    endfunction

    // called just after a rising edge; returns just after the edge that took the request
    task automatic send_request(input logic op, input logic [9:0] idx, input logic skin,
                                input logic [BOUND_W-1:0] bnd);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 4);
            start          <= 1'b0;
            i_opcode       <= 1'($urandom());
            i_object_index <= 10'($urandom());
            i_is_skinned   <= 1'($urandom());
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        i_opcode       <= op;
        i_object_index <= idx;
        i_is_skinned   <= skin;
        i_centre_x     <= bnd[31:0];
        i_centre_y     <= bnd[63:32];
        i_centre_z     <= bnd[95:64];
        i_bound_radius <= bnd[126:96];
        start          <= 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    // block idle and every result seen; visits can still be in flight after a tick
    task automatic settle_idle();
        start <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (pending_verdicts != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        burst_left = 0;
    endtask

    task automatic write_reg(input logic idx, input logic [1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic run_random(input int unsigned count);
        int k;
        int pick;
        int bitpos;
        // swap a few objects out so new indexes join
        repeat (3) begin
            k = $urandom_range(0, CREW - 1);
            crew_index[k]  = 10'($urandom());
            crew_bounds[k] = rand_bounds();
        end
        repeat (count) begin
            pick = $urandom_range(0, 99);
            if (pick < 22) begin
                send_request(OP_TICK, 10'($urandom()), 1'($urandom()), rand_bounds());
            end else if (pick < 28) begin
                k = $urandom_range(0, CREW - 1);
                send_request(OP_VISIT, $urandom_range(0, 1) ? crew_index[k] : 10'($urandom()),
                             1'b1, rand_bounds());
            end else if (pick < 36) begin
                send_request(OP_VISIT, 10'($urandom()), 1'b0, rand_bounds());
            end else begin
                k = $urandom_range(0, CREW - 1);
                if ($urandom_range(0, 15) == 0) begin
                    if ($urandom_range(0, 1)) begin
                        // a single bit of movement must still count
                        bitpos = $urandom_range(0, BOUND_W - 1);
                        crew_bounds[k][bitpos] = ~crew_bounds[k][bitpos];
                    end else begin
                        crew_bounds[k] = rand_bounds();
                    end
                end
                send_request(OP_VISIT, crew_index[k], 1'b0, crew_bounds[k]);
            end
        end
    endtask

    initial begin
        logic [BOUND_W-1:0] b_lo;
        logic [BOUND_W-1:0] b_hi;
        b_lo = pack_bounds(EXT_MIN, EXT_MAX, EXT_MIN, 31'd0);
        b_hi = pack_bounds(EXT_MAX, EXT_MIN, EXT_MAX, 31'h7fff_ffff);
        for (int i = 0; i < CREW; i++) begin
            crew_index[i]  = 10'($urandom());
            crew_bounds[i] = rand_bounds();
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part with reset register values
        send_request(OP_VISIT, 10'd0, 1'b0, b_lo);
        send_request(OP_VISIT, 10'd0, 1'b0, b_lo);
        send_request(OP_VISIT, 10'd1023, 1'b0, b_hi);
        send_request(OP_VISIT, 10'd0, 1'b1, b_hi);
        send_request(OP_TICK, 10'd0, 1'b0, '0);
        send_request(OP_VISIT, 10'd0, 1'b0, b_lo);
        repeat (8) send_request(OP_TICK, 10'd0, 1'b0, '0);
        send_request(OP_VISIT, 10'd0, 1'b0, b_lo);
        send_request(OP_VISIT, 10'd1023, 1'b0, b_hi);
        send_request(OP_TICK, 10'd1023, 1'b1, b_hi);
        // static object moves: backoff doubles
        send_request(OP_VISIT, 10'd0, 1'b0, b_lo ^ {1'b1, 126'd0});
        send_request(OP_VISIT, 10'd1023, 1'b0, b_hi);
        send_request(OP_VISIT, 10'd512, 1'b0, '0);

        settle_idle();
        write_reg(CFG_SPLIT_EN, 2'b01);
        write_reg(CFG_PASS_MODE, PASS_DYNAMIC);
        run_random(450);

        settle_idle();
        write_reg(CFG_PASS_MODE, PASS_STATIC);
        run_random(450);

        settle_idle();
        write_reg(CFG_SPLIT_EN, 2'b10);
        run_random(150);

        settle_idle();
        write_reg(CFG_SPLIT_EN, 2'b11);
        write_reg(CFG_PASS_MODE, PASS_UNUSED);
        run_random(450);

        settle_idle();
        write_reg(CFG_PASS_MODE, PASS_ALL);
        run_random(450);

        settle_idle();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0)
            $display("tb_object_mobility_classifier_core passed");
        else
            $display("tb_object_mobility_classifier_core failed");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("tb_object_mobility_classifier_core failed");
        $finish;
    end

endmodule
